/* src/mfs_pkg.sv */
`timescale 1ns / 1ps

package mfs_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned FreqW       = 7;

  localparam logic ActPush = 1'b0;
  localparam logic ActPop  = 1'b1;

  typedef enum logic [1:0] {
    StPush  = 2'd0,
    StPop   = 2'd1,
    StEmpty = 2'd2,
    StFull  = 2'd3
  } status_e;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CmdHold = 2'd0,
    CmdLook = 2'd1,
    CmdPush = 2'd2,
    CmdPop  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FsmIdle  = 2'd0,
    FsmLook  = 2'd1,
    FsmSum   = 2'd2,
    FsmApply = 2'd3
  } fsm_e;

  typedef struct packed {
    logic                     action;
    logic signed [ValueW-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] popped_value;
    logic [FreqW-1:0]         popped_frequency;
  } out_word_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [ValueW-1:0] value;
  } cell_ctl_t;

endpackage

/* src/mfs_cell.sv */
`timescale 1ns / 1ps

module mfs_cell #(
  parameter int unsigned LvlW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mfs_pkg::cell_ctl_t         ctl_i,
  input  logic [LvlW-1:0]            ins_lvl_i,
  input  logic                       prev_valid_i,
  input  logic                       prev_top_i,
  input  logic                       prev_hit_i,
  input  logic                       prev_gt_i,
  input  logic [mfs_pkg::ValueW-1:0] prev_value_i,
  input  logic [LvlW-1:0]            prev_lvl_i,
  input  logic                       next_valid_i,
  input  logic                       next_top_i,
  input  logic                       next_fix_i,
  input  logic [mfs_pkg::ValueW-1:0] next_value_i,
  input  logic [LvlW-1:0]            next_lvl_i,
  output logic                       valid_o,
  output logic                       top_o,
  output logic                       hit_o,
  output logic                       gt_o,
  output logic                       fix_o,
  output logic [mfs_pkg::ValueW-1:0] value_o,
  output logic [LvlW-1:0]            lvl_o
);

  logic                       valid_q, valid_d;
  logic                       hit_q, hit_d;
  logic                       top_q, top_d;
  logic [mfs_pkg::ValueW-1:0] value_q, value_d;
  logic [LvlW-1:0]            lvl_q, lvl_d;

  // entry sits above the insert point of a push
  assign gt_o  = valid_q && (lvl_q > ins_lvl_i);
  // on pop: this copy becomes the newest of its value
  assign fix_o = valid_q && (value_q == ctl_i.value) && (lvl_q == ins_lvl_i);

  always_comb begin
    valid_d = valid_q;
    hit_d   = hit_q;
    top_d   = top_q;
    value_d = value_q;
    lvl_d   = lvl_q;
    case (ctl_i.cmd)
      mfs_pkg::CmdLook: begin
        hit_d = valid_q && top_q && (value_q == ctl_i.value);
      end
      mfs_pkg::CmdPush: begin
        if (gt_o) begin
          top_d = top_q & ~hit_q;
        end else if (prev_gt_i) begin
          valid_d = 1'b1;
          top_d   = 1'b1;
          value_d = ctl_i.value;
          lvl_d   = ins_lvl_i;
        end else begin
          valid_d = prev_valid_i;
          top_d   = prev_top_i & ~prev_hit_i;
          value_d = prev_value_i;
          lvl_d   = prev_lvl_i;
        end
      end
      mfs_pkg::CmdPop: begin
        valid_d = next_valid_i;
        top_d   = next_top_i | next_fix_i;
        value_d = next_value_i;
        lvl_d   = next_lvl_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    value_q <= value_d;
    lvl_q   <= lvl_d;
  end

  assign valid_o = valid_q;
  assign top_o   = top_q;
  assign hit_o   = hit_q;
  assign value_o = value_q;
  assign lvl_o   = lvl_q;

endmodule

/* src/mfs_ctrl.sv */
`timescale 1ns / 1ps

module mfs_ctrl #(
  parameter int unsigned LvlW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mfs_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mfs_pkg::out_word_t         out_word_o,
  output mfs_pkg::cell_ctl_t         ctl_o,
  output logic [LvlW-1:0]            ins_lvl_o,
  input  logic [LvlW-1:0]            hit_lvl_i,
  input  logic                       head_valid_i,
  input  logic [mfs_pkg::ValueW-1:0] head_value_i,
  input  logic [LvlW-1:0]            head_lvl_i,
  input  logic                       full_i
);

  localparam int unsigned ExtW = (LvlW > mfs_pkg::FreqW) ? LvlW : mfs_pkg::FreqW;

  mfs_pkg::fsm_e      state_q, state_d;
  mfs_pkg::in_word_t  cmd_q, cmd_d;
  logic [LvlW-1:0]    cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  mfs_pkg::out_word_t out_word_q, out_word_d;
  logic               load_out;
  logic               out_free;
  logic [ExtW-1:0]    head_lvl_ext;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign head_lvl_ext = ExtW'(head_lvl_i);

  always_comb begin : next_state
    state_d = state_q;
    case (state_q)
      mfs_pkg::FsmIdle: begin
        if (in_valid_i) begin
          state_d = (in_word_i.action == mfs_pkg::ActPop) ? mfs_pkg::FsmApply
                                                          : mfs_pkg::FsmLook;
        end
      end
      mfs_pkg::FsmLook:  state_d = mfs_pkg::FsmSum;
      mfs_pkg::FsmSum:   state_d = mfs_pkg::FsmApply;
      mfs_pkg::FsmApply: begin
        if (out_free) begin
          state_d = mfs_pkg::FsmIdle;
        end
      end
      default: state_d = mfs_pkg::FsmIdle;
    endcase
  end

  always_comb begin : outputs
    in_stall_o = (state_q != mfs_pkg::FsmIdle);
    ctl_o.cmd   = mfs_pkg::CmdHold;
    ctl_o.value = cmd_q.value;
    ins_lvl_o   = '0;
    load_out    = 1'b0;
    out_word_d  = '0;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    case (state_q)
      mfs_pkg::FsmIdle: begin
        if (in_valid_i) begin
          cmd_d = in_word_i;
        end
      end
      mfs_pkg::FsmLook: begin
        ctl_o.cmd = mfs_pkg::CmdLook;
      end
      mfs_pkg::FsmSum: begin
        cnt_d = hit_lvl_i;
      end
      mfs_pkg::FsmApply: begin
        if (out_free) begin
          load_out = 1'b1;
          if (cmd_q.action == mfs_pkg::ActPush) begin
            if (full_i) begin
              out_word_d.status = mfs_pkg::StFull;
            end else begin
              ctl_o.cmd         = mfs_pkg::CmdPush;
              ins_lvl_o         = cnt_q + LvlW'(1);
              out_word_d.status = mfs_pkg::StPush;
            end
          end else begin
            if (!head_valid_i) begin
              out_word_d.status = mfs_pkg::StEmpty;
            end else begin
              ctl_o.cmd                   = mfs_pkg::CmdPop;
              ctl_o.value                 = head_value_i;
              ins_lvl_o                   = head_lvl_i - LvlW'(1);
              out_word_d.status           = mfs_pkg::StPop;
              out_word_d.popped_value     = head_value_i;
              out_word_d.popped_frequency = head_lvl_ext[mfs_pkg::FreqW-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfs_pkg::FsmIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cnt_q <= cnt_d;
    if (load_out) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* src/max_frequency_stack.sv */
`timescale 1ns / 1ps

// Maximum-frequency stack. A push stores a value and raises its count; a pop
// returns the most recently pushed value among those with the highest count,
// with that count, and lowers it. Storage is a row of Capacity cells kept
// sorted by frequency level (highest first), newest first within a level,
// so the word to pop always sits in cell 0 and a pop shifts the row up one
// cell. A push is a broadcast lookup (each cell compares against the value
// and flags the newest copy of it), a registered OR of the flagged level to
// get the current count, then an insert where every cell decides locally
// from its neighbor whether to keep, take the new word, or shift down.
// A push is accepted, then runs lookup, count and insert; a pop is accepted,
// then shifts. Insert and shift wait while a stalled result is held. One word
// is in the block at a time, and the next is taken while a finished result
// still waits in the output register. A push with every cell in use returns
// status full and is dropped; a pop on an empty row returns status empty. No
// clearing pass: the row is empty right after reset.
module max_frequency_stack #(
  parameter int unsigned Capacity = mfs_pkg::CapacityDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mfs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfs_pkg::out_word_t out_word_o
);

  // level runs 1..Capacity
  localparam int unsigned LvlW = $clog2(Capacity + 1);

  mfs_pkg::cell_ctl_t         ctl;
  logic [LvlW-1:0]            ins_lvl;
  logic [LvlW-1:0]            hit_lvl;

  logic [Capacity-1:0]        cell_valid;
  logic [Capacity-1:0]        cell_top;
  logic [Capacity-1:0]        cell_hit;
  logic [Capacity-1:0]        cell_gt;
  logic [Capacity-1:0]        cell_fix;
  logic [mfs_pkg::ValueW-1:0] cell_value [Capacity];
  logic [LvlW-1:0]            cell_lvl   [Capacity];

  // level bits of the hit cell, one column per bit
  logic [LvlW-1:0][Capacity-1:0] hit_col;

  for (genvar i = 0; i < Capacity; i++) begin : g_row
    logic                       p_valid, p_top, p_hit, p_gt;
    logic [mfs_pkg::ValueW-1:0] p_value;
    logic [LvlW-1:0]            p_lvl;
    logic                       n_valid, n_top, n_fix;
    logic [mfs_pkg::ValueW-1:0] n_value;
    logic [LvlW-1:0]            n_lvl;

    if (i == 0) begin : g_head
      // cell 0 takes the new word whenever nothing outranks it
      assign p_valid = 1'b0;
      assign p_top   = 1'b0;
      assign p_hit   = 1'b0;
      assign p_gt    = 1'b1;
      assign p_value = '0;
      assign p_lvl   = '0;
    end else begin : g_prev
      assign p_valid = cell_valid[i-1];
      assign p_top   = cell_top[i-1];
      assign p_hit   = cell_hit[i-1];
      assign p_gt    = cell_gt[i-1];
      assign p_value = cell_value[i-1];
      assign p_lvl   = cell_lvl[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_top   = 1'b0;
      assign n_fix   = 1'b0;
      assign n_value = '0;
      assign n_lvl   = '0;
    end else begin : g_next
      assign n_valid = cell_valid[i+1];
      assign n_top   = cell_top[i+1];
      assign n_fix   = cell_fix[i+1];
      assign n_value = cell_value[i+1];
      assign n_lvl   = cell_lvl[i+1];
    end

    mfs_cell #(
      .LvlW (LvlW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .ins_lvl_i    (ins_lvl),
      .prev_valid_i (p_valid),
      .prev_top_i   (p_top),
      .prev_hit_i   (p_hit),
      .prev_gt_i    (p_gt),
      .prev_value_i (p_value),
      .prev_lvl_i   (p_lvl),
      .next_valid_i (n_valid),
      .next_top_i   (n_top),
      .next_fix_i   (n_fix),
      .next_value_i (n_value),
      .next_lvl_i   (n_lvl),
      .valid_o      (cell_valid[i]),
      .top_o        (cell_top[i]),
      .hit_o        (cell_hit[i]),
      .gt_o         (cell_gt[i]),
      .fix_o        (cell_fix[i]),
      .value_o      (cell_value[i]),
      .lvl_o        (cell_lvl[i])
    );

    for (genvar b = 0; b < LvlW; b++) begin : g_col
      assign hit_col[b][i] = cell_hit[i] & cell_lvl[i][b];
    end
  end

  // at most one cell hits, so an OR per bit yields its level (zero if none)
  for (genvar b = 0; b < LvlW; b++) begin : g_or
    assign hit_lvl[b] = |hit_col[b];
  end

  mfs_ctrl #(
    .LvlW (LvlW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o),
    .ctl_o        (ctl),
    .ins_lvl_o    (ins_lvl),
    .hit_lvl_i    (hit_lvl),
    .head_valid_i (cell_valid[0]),
    .head_value_i (cell_value[0]),
    .head_lvl_i   (cell_lvl[0]),
    .full_i       (cell_valid[Capacity-1])
  );

`ifndef SYNTHESIS
  // occupied cells always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied cells not contiguous");

  // only the newest copy of a value may hit
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_hit))
    else $error("more than one cell hit");

  // row stays sorted at the head
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[1] |-> (cell_lvl[0] >= cell_lvl[1]))
    else $error("head cells out of level order");

  // one word in flight: no acceptance right after an acceptance
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while busy");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  // Checks max_frequency_stack against a shadow stack. The shadow keeps every
  // stored copy in push order, each tagged with the frequency level it landed
  // on. A pop takes the newest copy on the highest level. Result words are
  // compared field by field against the queue of due words, in order.

  localparam int unsigned Slots      = mfs_pkg::CapacityDef;
  localparam int unsigned HoldCycles = 48;      // long receiver hold-off
  localparam int unsigned CycleLimit = 200000;  // watchdog

  logic               clk = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  mfs_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  mfs_pkg::out_word_t out_word;

  always #5 clk = ~clk;

  max_frequency_stack dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // Shadow of the frequency stack plus the queue of result words still due.
  class freq_stack_shadow;
    typedef struct {
      logic [mfs_pkg::ValueW-1:0] value;
      int unsigned                level;  // 0-based level the copy sits on
    } copy_t;

    copy_t              copies[$];        // push order, oldest first
    int unsigned        level_fill[Slots]; // copies per level
    int unsigned        top_level;        // non-empty levels, 0 = empty
    int unsigned        tally[logic [mfs_pkg::ValueW-1:0]];
    mfs_pkg::out_word_t due_words[$];
    int unsigned errors, pushes, pops, empties, fulls, peak_freq, replies;

    function new();
      foreach (level_fill[i]) level_fill[i] = 0;
      top_level = 0;
      errors    = 0;
      pushes    = 0;
      pops      = 0;
      empties   = 0;
      fulls     = 0;
      peak_freq = 0;
      replies   = 0;
    endfunction

    function int unsigned held();
      return copies.size();
    endfunction

    function int unsigned waiting();
      return due_words.size();
    endfunction

    // accepted command word: update the shadow and queue its result
    function void note_command(mfs_pkg::in_word_t w);
      mfs_pkg::out_word_t         r;
      logic [mfs_pkg::ValueW-1:0] v;
      int unsigned                c;
      int                         i;
      copy_t                      cp;
      r = '0;
      if (w.action == mfs_pkg::ActPush) begin
        v = w.value;
        if (copies.size() == Slots) begin
          // every slot taken: dropped, nothing changes
          r.status = mfs_pkg::StFull;
          fulls++;
        end else begin
          c = tally.exists(v) ? tally[v] : 0;
          cp.value = v;
          cp.level = c;
          copies.insert(copies.size(), cp);
          level_fill[c]++;
          tally[v] = c + 1;
          if (c + 1 > top_level) top_level = c + 1;
          r.status = mfs_pkg::StPush;
          pushes++;
        end
      end else if (top_level == 0) begin
        r.status = mfs_pkg::StEmpty;
        empties++;
      end else begin
        // newest copy on the highest level
        i = copies.size() - 1;
        while (copies[i].level != top_level - 1) i--;
        v = copies[i].value;
        copies.delete(i);
        level_fill[top_level-1]--;
        r.status           = mfs_pkg::StPop;
        r.popped_value     = v;
        r.popped_frequency = top_level[mfs_pkg::FreqW-1:0];
        if (top_level > peak_freq) peak_freq = top_level;
        tally[v]--;
        if (tally[v] == 0) tally.delete(v);
        if (level_fill[top_level-1] == 0) top_level--;
        pops++;
      end
      due_words.insert(due_words.size(), r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_reply(mfs_pkg::out_word_t got);
      mfs_pkg::out_word_t want;
      replies++;
      if (due_words.size() == 0) begin
        report($sformatf("word %0d: none due, got status %0d", replies, got.status));
        return;
      end
      want = due_words.pop_front();
      if (got.status != want.status)
        report($sformatf("word %0d: status %0d, want %0d", replies, got.status,
                         want.status));
      if (got.popped_value != want.popped_value)
        report($sformatf("word %0d: popped_value %h, want %h", replies,
                         got.popped_value, want.popped_value));
      if (got.popped_frequency != want.popped_frequency)
        report($sformatf("word %0d: popped_frequency %0d, want %0d", replies,
                         got.popped_frequency, want.popped_frequency));
    endtask
  endclass

  freq_stack_shadow           board;
  bit                         calm;      // last part of the run: no idling at all
  bit                         hold_req;  // asks the stall process for a long hold-off
  int unsigned                cycles = 0;
  logic [mfs_pkg::ValueW-1:0] pool[6];   // small value set so counts climb

  // Sender: optional gap, then hold the word until accepted.
  task automatic issue_cmd(logic act, logic [mfs_pkg::ValueW-1:0] v);
    mfs_pkg::in_word_t w;
    w.action = act;
    w.value  = v;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    board.note_command(w);
  endtask

  function automatic logic [mfs_pkg::ValueW-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  task automatic run_mix(int n, int push_pct);
    repeat (n) begin
      issue_cmd(($urandom_range(0, 99) < push_pct) ? mfs_pkg::ActPush
                                                   : mfs_pkg::ActPop,
                pick_value());
    end
  endtask

  // pop until the shadow holds nothing
  task automatic drain();
    while (board.held() != 0) issue_cmd(mfs_pkg::ActPop, $urandom());
  endtask

  // Receiver stall: random bursts, or one long hold-off when
  // asked. One assignment per falling edge.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) board.check_reply(out_word);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic [mfs_pkg::ValueW-1:0] v;
    board     = new();
    calm      = 1'b0;
    hold_req  = 1'b0;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    pool[0]   = 32'h7fff_ffff;
    pool[1]   = 32'h8000_0000;
    pool[2]   = 32'h0000_0000;
    pool[3]   = 32'hffff_ffff;
    pool[4]   = $urandom();
    pool[5]   = $urandom();

    repeat (12) @(posedge clk);
    @(negedge clk) rst_ni <= 1'b1;

    // Directed: pop on empty, extreme values, a repeated value on level 2,
    // a tie on the top level broken by push order, then back to empty.
    issue_cmd(mfs_pkg::ActPop, 32'h1234_5678);
    issue_cmd(mfs_pkg::ActPush, 32'h7fff_ffff);
    issue_cmd(mfs_pkg::ActPush, 32'h8000_0000);
    issue_cmd(mfs_pkg::ActPush, 32'h0000_0000);
    issue_cmd(mfs_pkg::ActPush, 32'hffff_ffff);
    issue_cmd(mfs_pkg::ActPush, 32'h8000_0000);
    repeat (5) issue_cmd(mfs_pkg::ActPop, 32'hffff_ffff);
    issue_cmd(mfs_pkg::ActPop, 32'h0000_0000);
    issue_cmd(mfs_pkg::ActPush, 32'd5);
    issue_cmd(mfs_pkg::ActPush, 32'd9);
    issue_cmd(mfs_pkg::ActPush, 32'd5);
    issue_cmd(mfs_pkg::ActPush, 32'd9);
    repeat (5) issue_cmd(mfs_pkg::ActPop, $urandom());

    // Random mixes: build up, then wind down.
    run_mix(100, 70);
    run_mix(50, 35);

    // One value to the top frequency, a dropped push on a full store, then
    // every level popped down and one pop past empty.
    drain();
    v = pick_value();
    repeat (Slots) issue_cmd(mfs_pkg::ActPush, v);
    issue_cmd(mfs_pkg::ActPush, ~v);
    repeat (Slots + 1) issue_cmd(mfs_pkg::ActPop, $urandom());

    // Fill with mixed values, a few dropped pushes, empty again.
    while (board.held() < Slots) issue_cmd(mfs_pkg::ActPush, pick_value());
    repeat (3) issue_cmd(mfs_pkg::ActPush, $urandom());
    drain();

    // Long receiver hold-off while words keep coming: block backs up.
    hold_req = 1'b1;
    run_mix(100, 55);

    // last stretch with no idling on either side
    calm = 1'b1;
    run_mix(80, 55);

    @(negedge clk) in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run: %0d pushes, %0d pops, %0d pops on empty, %0d dropped pushes",
             board.pushes, board.pops, board.empties, board.fulls);
    $display("run: top frequency popped %0d, %0d result words checked",
             board.peak_freq, board.replies);
    if (board.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
